>>> rtl/slpd_pkg.sv
// Package: shared constants and types for the sync/length packet deframer.
`timescale 1ns / 1ps
package slpd_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int HDR_DATA_W = 8 * HEADER_BYTES;
  localparam int HDR_IDX_W = $clog2(HEADER_BYTES);
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic [7:0] SYNC_FIRST = 8'hFD;
  localparam logic [7:0] SYNC_SECOND = 8'hDF;
  localparam logic [8:0] SIZE_OVERHEAD = 9'd8;
  localparam logic [8:0] EXPECTED_SIZE_RESET = 9'd8;
  localparam logic [8:0] HDR_LAST_POS = 9'(HEADER_BYTES - 1);
  localparam logic [8:0] HDR_START_POS = 9'd2;

  // queue entry: a full header (six bytes, byte 0 lowest) or one body byte
  typedef struct packed {
    logic                  hdr;
    logic                  last;
    logic [HDR_DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/sync_length_packet_deframer_core.sv
// Top level of the sync/length packet deframer.
// Body: a body byte is written to the queue, then registered onto m_tdata/m_tvalid.
// Header: on size match, the six bytes follow byte 5, one per cycle unless stalled.
// Throughput: one input byte per cycle; input stalls only when the queue fills.
// Reset: rst is synchronous; clears state, queue, output valid, expected size 8.
`timescale 1ns / 1ps
module sync_length_packet_deframer_core #(
  parameter int QUEUE_DEPTH = slpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // last_byte
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data   // [8:0] expected_size
);

  slpd_pkg::q_status_t q_status;
  slpd_pkg::entry_t    push_entry;
  slpd_pkg::entry_t    head;
  logic push;
  logic pop;

  assign cfg_ready = 1'b1;

  slpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_wdata  (cfg_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  slpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  slpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

>>> rtl/slpd_queue.sv
// Short queue of command entries between the classifier and the emitter.
`timescale 1ns / 1ps
module slpd_queue #(
  parameter int DEPTH = slpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  slpd_pkg::entry_t  push_entry,
  input  logic              pop,
  output slpd_pkg::entry_t  head,
  output slpd_pkg::q_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  slpd_pkg::entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign status.full = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/slpd_front.sv
// Front end: sync hunt, header capture, size check and packet tracking.
`timescale 1ns / 1ps
module slpd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata,
  input  slpd_pkg::q_status_t q_status,
  output logic                push,
  output slpd_pkg::entry_t    push_entry
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_SKIP,
    PH_BODY
  } phase_t;

  phase_t      phase;
  logic [7:0]  prev_byte;
  logic [8:0]  pos;
  logic [8:0]  pkt_len;
  logic [8:0]  expected_size;
  logic [7:0]  hdr [2:slpd_pkg::HEADER_BYTES-2];
  logic        accept;
  logic [8:0]  pos_next;
  logic [8:0]  size_now;
  logic        size_match;
  logic        at_end;

  assign in_ready = !q_status.full;
  assign accept = in_valid && in_ready;
  assign pos_next = pos + 9'd1;
  assign size_now = {1'b0, in_byte} + slpd_pkg::SIZE_OVERHEAD;
  assign size_match = (size_now == expected_size);
  assign at_end = (pos_next >= pkt_len);

  always_comb begin
    push = 1'b0;
    push_entry.hdr = 1'b0;
    push_entry.last = 1'b0;
    push_entry.data = {{(slpd_pkg::HDR_DATA_W - 8){1'b0}}, in_byte};
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (pos == slpd_pkg::HDR_LAST_POS && size_match) begin
            push = 1'b1;
            push_entry.hdr = 1'b1;
            push_entry.data = {in_byte, hdr[4], hdr[3], hdr[2],
                               slpd_pkg::SYNC_SECOND, slpd_pkg::SYNC_FIRST};
          end
        end
        PH_BODY: begin
          push = 1'b1;
          push_entry.last = at_end;
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_HEADER && pos < slpd_pkg::HDR_LAST_POS) begin
      hdr[pos[2:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      prev_byte <= '0;
      pos <= '0;
      pkt_len <= '0;
      expected_size <= slpd_pkg::EXPECTED_SIZE_RESET;
    end else begin
      if (cfg_we) begin
        expected_size <= cfg_wdata;
      end
      if (accept) begin
        unique case (phase)
          PH_HUNT: begin
            if (prev_byte == slpd_pkg::SYNC_FIRST && in_byte == slpd_pkg::SYNC_SECOND) begin
              pos <= slpd_pkg::HDR_START_POS;
              phase <= PH_HEADER;
              prev_byte <= '0;
            end else begin
              prev_byte <= in_byte;
            end
          end
          PH_HEADER: begin
            pos <= pos_next;
            if (pos == slpd_pkg::HDR_LAST_POS) begin
              pkt_len <= size_now;
              phase <= size_match ? PH_BODY : PH_SKIP;
            end
          end
          PH_SKIP, PH_BODY: begin
            pos <= pos_next;
            if (at_end) begin
              phase <= PH_HUNT;
              prev_byte <= '0;
              pos <= '0;
            end
          end
          default: phase <= PH_HUNT;
        endcase
      end
    end
  end

endmodule

>>> rtl/slpd_back.sv
// Back end: expands queue entries into output byte transfers.
`timescale 1ns / 1ps
module slpd_back (
  input  logic                clk,
  input  logic                rst,
  input  slpd_pkg::entry_t    head,
  input  slpd_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  logic [slpd_pkg::HDR_IDX_W-1:0] idx;
  logic load;
  logic hdr_done;

  assign load = !q_status.empty && (!out_valid || out_ready);
  assign hdr_done = (idx == slpd_pkg::HDR_IDX_W'(slpd_pkg::HEADER_BYTES - 1));
  assign pop = load && (!head.hdr || hdr_done);

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.hdr ? head.data[8*idx +: 8] : head.data[7:0];
      out_last <= head.hdr ? 1'b0 : head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && !out_ready);
      if (pop) begin
        idx <= '0;
      end else if (load) begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

>>> rtl/slpd_checker.sv
// Port-level checker for the deframer, bound to the top level.
`timescale 1ns / 1ps
module slpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [8:0] cfg_data
);

  // stalled output transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // output register empty right after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  // input back-pressure only when the output side is backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with idle output");

  // configuration always taken out of reset
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind sync_length_packet_deframer_core slpd_checker u_slpd_checker (.*);
